### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// types and constants of the daily alarm table
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int ENTRY_SLOTS = 8;
  localparam int IDX_W       = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ENTRY_SLOTS + 1);
  localparam int COUNT_W     = 4;
  localparam int SEC_W       = 32;
  localparam int FIRE_WINDOW = 60;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_OVERWRITE = 3'd2,
    MODE_REMOVE    = 3'd3,
    MODE_READ      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    KIND_FIRE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       slot;
    logic [4:0]       entry_hour;
    logic [5:0]       entry_minute;
    logic [7:0]       entry_amount;
    logic             entry_enabled;
    logic [4:0]       clock_hour;
    logic [5:0]       clock_minute;
    logic [SEC_W-1:0] clock_seconds;
  } alarm_in_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [2:0]         fired_slot;
    logic [4:0]         out_hour;
    logic [5:0]         out_minute;
    logic [7:0]         out_amount;
    logic               out_enabled;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } alarm_res_t;

  typedef struct packed {
    logic       enabled;
    logic [7:0] amount;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic walk;
    logic emit;
    logic shift;
    logic stat;
  } dat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic range_err;
    logic mask_empty;
    logic out_free;
  } dat_sts_t;

endpackage

### src/dat_ctrl.sv
// ----------------------------------------------------------------------------
// dat_ctrl
// sequencer for ticks, table edits and result delivery
// ----------------------------------------------------------------------------
module dat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        mode_i,
  output logic              in_ready_o,
  output dat_pkg::dat_cmd_t cmd_o,
  input  dat_pkg::dat_sts_t sts_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_EMIT  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_STAT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (mode_i)
            dat_pkg::MODE_TICK:   state_d = S_WALK;
            dat_pkg::MODE_REMOVE: state_d = S_SHIFT;
            dat_pkg::MODE_APPEND, dat_pkg::MODE_OVERWRITE, dat_pkg::MODE_READ: begin
              state_d = S_STAT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.mask_empty) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.range_err || sts_i.idx_last) begin
          state_d = S_STAT;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.stat = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/dat_datapath.sv
// ----------------------------------------------------------------------------
// dat_datapath
// alarm table storage, match walk, shift and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dat_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dat_pkg::alarm_in_t  in_data_i,
  input  dat_pkg::dat_cmd_t   cmd_i,
  output dat_pkg::dat_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dat_pkg::alarm_res_t out_data_o
);

  localparam int IW = dat_pkg::IDX_W;
  localparam int CW = dat_pkg::CNT_W;
  localparam int NS = dat_pkg::ENTRY_SLOTS;
  localparam int SW = dat_pkg::SEC_W;

  dat_pkg::entry_t     ent_q [NS];
  logic [SW-1:0]       lft_q [NS];
  logic [CW-1:0]       used_q, used_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [NS-1:0]       mask_q, mask_d;
  dat_pkg::alarm_in_t  in_q;
  logic                out_valid_q, out_valid_d;
  dat_pkg::alarm_res_t out_q, res_d;

  logic [IW-1:0]   rd_addr, slot_idx, fire_idx;
  dat_pkg::entry_t ent_rd, in_ent;
  logic [SW-1:0]   lft_rd;
  logic            ent_we, lft_we, res_ld, match, full, range_err;
  logic            out_free, emit_last, idx_last;
  logic [IW-1:0]   ent_waddr, lft_waddr;
  dat_pkg::entry_t ent_wdata;
  logic [SW-1:0]   lft_wdata;
  logic [NS-1:0]   fire_oh;

  assign slot_idx  = IW'(in_q.slot);
  assign out_free  = !out_valid_q || out_ready_i;
  assign full      = used_q >= CW'(NS);
  assign range_err = 8'(in_q.slot) >= 8'(used_q);
  assign idx_last  = (CW'(idx_q) + CW'(1)) >= used_q;

  assign in_ent.enabled = in_q.entry_enabled;
  assign in_ent.amount  = in_q.entry_amount;
  assign in_ent.hour    = in_q.entry_hour;
  assign in_ent.minute  = in_q.entry_minute;

  // lowest pending firing
  always_comb begin
    fire_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        fire_idx = IW'(i);
      end
    end
  end

  assign fire_oh   = NS'(1) << fire_idx;
  assign emit_last = (mask_q & ~fire_oh) == '0;

  always_comb begin
    rd_addr = idx_q;
    if (cmd_i.shift) begin
      rd_addr = idx_q + IW'(1);
    end else if (cmd_i.emit) begin
      rd_addr = fire_idx;
    end else if (cmd_i.stat) begin
      rd_addr = slot_idx;
    end
  end

  assign ent_rd = ent_q[rd_addr];
  assign lft_rd = lft_q[rd_addr];

  assign match = ent_rd.enabled
              && (ent_rd.hour == in_q.clock_hour)
              && (ent_rd.minute == in_q.clock_minute)
              && ({1'b0, in_q.clock_seconds} >= ({1'b0, lft_rd} + (SW+1)'(dat_pkg::FIRE_WINDOW)))
              && (CW'(idx_q) < used_q);

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = idx_q;
    ent_wdata = ent_rd;
    lft_we    = 1'b0;
    lft_waddr = idx_q;
    lft_wdata = lft_rd;
    used_d    = used_q;
    idx_d     = idx_q;
    mask_d    = mask_q;
    res_ld    = 1'b0;
    res_d     = '0;
    res_d.entry_count = dat_pkg::COUNT_W'(used_q);

    if (cmd_i.load_in) begin
      mask_d = '0;
      idx_d  = (in_data_i.mode == dat_pkg::MODE_REMOVE) ? IW'(in_data_i.slot) : '0;
    end

    if (cmd_i.walk) begin
      idx_d = idx_q + IW'(1);
      if (match) begin
        mask_d[idx_q] = 1'b1;
        lft_we        = 1'b1;
        lft_wdata     = in_q.clock_seconds;
      end
    end

    if (cmd_i.shift) begin
      idx_d  = idx_q + IW'(1);
      ent_we = 1'b1;
      lft_we = 1'b1;
    end

    if (cmd_i.emit) begin
      res_ld            = 1'b1;
      mask_d            = mask_q & ~fire_oh;
      res_d.kind        = dat_pkg::KIND_FIRE;
      res_d.status      = dat_pkg::ST_OK;
      res_d.fired_slot  = 3'(fire_idx);
      res_d.out_hour    = ent_rd.hour;
      res_d.out_minute  = ent_rd.minute;
      res_d.out_amount  = ent_rd.amount;
      res_d.out_enabled = ent_rd.enabled;
      res_d.last        = emit_last;
    end

    if (cmd_i.stat) begin
      res_ld           = 1'b1;
      res_d.kind       = dat_pkg::KIND_STATUS;
      res_d.last       = 1'b1;
      res_d.fired_slot = in_q.slot;
      res_d.status     = dat_pkg::ST_OK;
      if (in_q.mode == dat_pkg::MODE_APPEND) begin
        if (full) begin
          res_d.status     = dat_pkg::ST_FULL;
          res_d.fired_slot = '0;
        end else begin
          ent_we            = 1'b1;
          ent_waddr         = IW'(used_q);
          ent_wdata         = in_ent;
          lft_we            = 1'b1;
          lft_waddr         = IW'(used_q);
          lft_wdata         = '0;
          used_d            = used_q + CW'(1);
          res_d.fired_slot  = 3'(used_q);
          res_d.entry_count = dat_pkg::COUNT_W'(used_q + CW'(1));
        end
      end else if (range_err) begin
        res_d.status = dat_pkg::ST_RANGE;
      end else if (in_q.mode == dat_pkg::MODE_OVERWRITE) begin
        ent_we    = 1'b1;
        ent_waddr = slot_idx;
        ent_wdata = in_ent;
      end else if (in_q.mode == dat_pkg::MODE_REMOVE) begin
        used_d            = used_q - CW'(1);
        res_d.entry_count = dat_pkg::COUNT_W'(used_q - CW'(1));
      end else begin
        res_d.out_hour    = ent_rd.hour;
        res_d.out_minute  = ent_rd.minute;
        res_d.out_amount  = ent_rd.amount;
        res_d.out_enabled = ent_rd.enabled;
      end
    end

    out_valid_d = out_valid_q;
    if (res_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        lft_q[i] <= '0;
      end
    end else begin
      used_q      <= used_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      if (lft_we) begin
        lft_q[lft_waddr] <= lft_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_q[ent_waddr] <= ent_wdata;
    end
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (res_ld) begin
      out_q <= res_d;
    end
  end

  assign sts_o.idx_last   = idx_last;
  assign sts_o.range_err  = range_err;
  assign sts_o.mask_empty = (mask_q == '0);
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= CW'(NS))
  `ASSERT_ALWAYS(a_no_result_clobber, clk_i, rst_ni, !(res_ld && !out_free))
  `ASSERT_NEXT(a_mask_drained, clk_i, rst_ni, cmd_i.emit && emit_last, mask_q == '0)

endmodule

### src/daily_alarm_table.sv
// ----------------------------------------------------------------------------
// daily_alarm_table
// table of daily alarms with tick matching and table edit operations
// ----------------------------------------------------------------------------
// One item is handled at a time through a single table read port. A tick walks
// the stored entries one per cycle, then delivers one fire transaction per match
// in ascending slot order, each once the output register is free. A remove
// shifts the later entries down one per cycle before its status; append,
// overwrite and read go straight to their status. Results leave through an
// output register, so a waiting result does not block the next input.
// ----------------------------------------------------------------------------
module daily_alarm_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dat_pkg::alarm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dat_pkg::alarm_res_t out_data_o
);

  dat_pkg::dat_cmd_t cmd;
  dat_pkg::dat_sts_t sts;

  dat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dat_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
